/* rtl/gac_pkg.sv */
// ----------------------------------------------------------------------------
// gac_pkg
// shared constants and types of the gamepad axis conditioner
// ----------------------------------------------------------------------------
`default_nettype none

package gac_pkg;

  // pad storage
  localparam int unsigned NUM_PADS   = 8;
  localparam int unsigned WHEEL_PADS = 4;
  localparam int unsigned PAD_AW     = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

  // controller type codes
  localparam logic [7:0] ID_ANALOG_STICK = 8'h53;
  localparam logic [7:0] ID_ANALOG       = 8'h73;
  localparam logic [7:0] ID_TWIST        = 8'h23;
  localparam logic [7:0] ID_JOG          = 8'hE3;

  // axis constants
  localparam logic [7:0] AXIS_CENTRE = 8'h80;
  localparam logic [7:0] AXIS_MIN    = 8'h00;
  localparam logic [7:0] AXIS_MAX    = 8'hFF;
  localparam logic [7:0] LY_GLITCH   = 8'hFF;
  // distance of 0x31 from centre: at or above 0xb1, at or below 0x4f
  localparam logic [7:0] ACT_HIGH    = 8'hB1;
  localparam logic [7:0] ACT_LOW     = 8'h4F;
  localparam logic [17:0] JOG_OFFSET = 18'd10;

  // configuration register map
  typedef enum logic [1:0] {
    REG_LEFT_MASK  = 2'd0,
    REG_RIGHT_MASK = 2'd1,
    REG_UP_MASK    = 2'd2,
    REG_DOWN_MASK  = 2'd3
  } cfg_reg_e;

  localparam logic [15:0] LEFT_MASK_RST  = 16'd4;
  localparam logic [15:0] RIGHT_MASK_RST = 16'd8;
  localparam logic [15:0] UP_MASK_RST    = 16'd1;
  localparam logic [15:0] DOWN_MASK_RST  = 16'd2;

  typedef struct packed {
    logic [2:0]  pad_index;
    logic        report_present;
    logic        plugged_in;
    logic [7:0]  controller_id;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  twist;
    logic [15:0] jog_rotation;
    logic [15:0] buttons_held;
    logic [7:0]  dead_zone;
  } report_t;

  typedef struct packed {
    logic [7:0] lx;
    logic [7:0] ly;
    logic [7:0] rx;
    logic [7:0] ry;
  } axes_t;

  typedef struct packed {
    logic [2:0] pad_index;
    axes_t      raw;
    logic [7:0] resolved_x;
    logic [7:0] resolved_y;
    logic       activity_seen;
    logic [7:0] jog_force;
    logic       jog_force_valid;
    logic       wheel_attached;
  } result_t;

  localparam axes_t AXES_CENTRE = '{AXIS_CENTRE, AXIS_CENTRE, AXIS_CENTRE, AXIS_CENTRE};

  function automatic logic far_from_centre(input logic [7:0] v);
    far_from_centre = (v >= ACT_HIGH) || (v <= ACT_LOW);
  endfunction

  function automatic logic [7:0] resolve_axis(input logic [7:0]  raw,
                                              input logic [15:0] held,
                                              input logic [15:0] neg,
                                              input logic [15:0] pos,
                                              input logic        follow);
    if ((held & neg) != '0) begin
      resolve_axis = AXIS_MIN;
    end else if ((held & pos) != '0) begin
      resolve_axis = AXIS_MAX;
    end else begin
      resolve_axis = follow ? raw : AXIS_CENTRE;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/gamepad_axis_conditioner_top.sv */
// ----------------------------------------------------------------------------
// gamepad_axis_conditioner_top
// per-pad controller report conditioning: raw axes, glitch filter, jog, override
// ----------------------------------------------------------------------------
// path: an accepted input transaction passes the input register, then one
//   compute step into the output (result) register
// throughput: one transaction per cycle unless stalled; per-pad state is updated at the edge
//   the result is registered, so a report for the same pad may follow at once
// reset: asynchronous active low; all pads come up with centred axes,
//   previous left-y cleared and the button masks at their defaults
`default_nettype none

module gamepad_axis_conditioner_top import gac_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,

  // report channel
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [2:0]  pad_index_i,
  input  wire logic        report_present_i,
  input  wire logic        plugged_in_i,
  input  wire logic [7:0]  controller_id_i,
  input  wire logic [7:0]  left_x_i,
  input  wire logic [7:0]  left_y_i,
  input  wire logic [7:0]  right_x_i,
  input  wire logic [7:0]  right_y_i,
  input  wire logic [7:0]  twist_i,
  input  wire logic signed [15:0] jog_rotation_i,
  input  wire logic [15:0] buttons_held_i,
  input  wire logic [7:0]  dead_zone_i,

  // result channel
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [2:0]  out_pad_index_o,
  output      logic [7:0]  raw_left_x_o,
  output      logic [7:0]  raw_left_y_o,
  output      logic [7:0]  raw_right_x_o,
  output      logic [7:0]  raw_right_y_o,
  output      logic [7:0]  resolved_x_o,
  output      logic [7:0]  resolved_y_o,
  output      logic        activity_seen_o,
  output      logic [7:0]  jog_force_o,
  output      logic        jog_force_valid_o,
  output      logic        wheel_attached_o
);

  // --------------------------------------------------------------------------
  // configuration registers: button masks
  // --------------------------------------------------------------------------
  logic [15:0] left_mask_q, right_mask_q, up_mask_q, down_mask_q;
  logic        cfg_wr;
  cfg_reg_e    cfg_addr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_addr = cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_mask_q  <= LEFT_MASK_RST;
      right_mask_q <= RIGHT_MASK_RST;
      up_mask_q    <= UP_MASK_RST;
      down_mask_q  <= DOWN_MASK_RST;
    end else if (cfg_wr) begin
      unique case (cfg_addr)
        REG_LEFT_MASK:  left_mask_q  <= pwdata[15:0];
        REG_RIGHT_MASK: right_mask_q <= pwdata[15:0];
        REG_UP_MASK:    up_mask_q    <= pwdata[15:0];
        REG_DOWN_MASK:  down_mask_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    unique case (cfg_addr)
      REG_LEFT_MASK:  prdata = {16'd0, left_mask_q};
      REG_RIGHT_MASK: prdata = {16'd0, right_mask_q};
      REG_UP_MASK:    prdata = {16'd0, up_mask_q};
      REG_DOWN_MASK:  prdata = {16'd0, down_mask_q};
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // handshake: input register -> compute -> result register
  // --------------------------------------------------------------------------
  logic    s1_valid_q, s1_valid_d;
  report_t s1_q;
  logic    out_valid_q, out_valid_d;
  result_t out_q, res_d;
  logic    in_fire, advance;

  // the input register moves on whenever the result register is free or drains
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_fire || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= '{pad_index:      pad_index_i,
                report_present: report_present_i,
                plugged_in:     plugged_in_i,
                controller_id:  controller_id_i,
                left_x:         left_x_i,
                left_y:         left_y_i,
                right_x:        right_x_i,
                right_y:        right_y_i,
                twist:          twist_i,
                jog_rotation:   jog_rotation_i,
                buttons_held:   buttons_held_i,
                dead_zone:      dead_zone_i};
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  // --------------------------------------------------------------------------
  // per-pad state: raw axes and last left-y of an analog pad
  // --------------------------------------------------------------------------
  axes_t             raw_axes_q [NUM_PADS];
  logic [7:0]        prev_ly_q  [NUM_PADS];
  logic [PAD_AW-1:0] pad_idx;
  logic              pad_ok;
  axes_t             raw_cur, raw_new;
  logic [7:0]        prev_cur;
  logic              raw_we, prev_we;

  assign pad_idx  = PAD_AW'(s1_q.pad_index);
  assign pad_ok   = 5'(s1_q.pad_index) < 5'(NUM_PADS);
  assign raw_cur  = raw_axes_q[pad_idx];
  assign prev_cur = prev_ly_q[pad_idx];

  // --------------------------------------------------------------------------
  // report decode
  // --------------------------------------------------------------------------
  logic        is_analog, is_twist, is_jog, follow, wheel_pad;
  logic [7:0]  ly_filt;
  logic [16:0] rot_ext, jog_mag;
  logic [17:0] jog_diff;
  logic [7:0]  jog_force, jog_x;
  logic        rot_lo, rot_hi;

  assign is_analog = (s1_q.controller_id == ID_ANALOG_STICK) ||
                     (s1_q.controller_id == ID_ANALOG);
  assign is_twist  = s1_q.controller_id == ID_TWIST;
  assign is_jog    = s1_q.controller_id == ID_JOG;
  assign follow    = is_analog || is_twist || is_jog;
  assign wheel_pad = 5'(s1_q.pad_index) < 5'(WHEEL_PADS);

  // left-y glitch filter: a stray 0xff is replaced by the previous byte
  assign ly_filt = ((s1_q.left_y == LY_GLITCH) && (prev_cur != LY_GLITCH)) ?
                   prev_cur : s1_q.left_y;

  // jog force: (|rot| - 10 - dead zone) * 8, clamped to a byte
  assign rot_ext  = {s1_q.jog_rotation[15], s1_q.jog_rotation};
  assign jog_mag  = s1_q.jog_rotation[15] ? (17'd0 - rot_ext) : rot_ext;
  assign jog_diff = {1'b0, jog_mag} - JOG_OFFSET - {10'd0, s1_q.dead_zone};

  always_comb begin
    if (jog_diff[17]) begin
      jog_force = 8'd0;
    end else if (jog_diff[16:5] != '0) begin
      jog_force = AXIS_MAX;
    end else begin
      jog_force = {jog_diff[4:0], 3'b000};
    end
  end

  // jog x: rotation clamped to -128..127, offset by 128
  assign rot_lo = s1_q.jog_rotation[15] && !(&s1_q.jog_rotation[14:7]);
  assign rot_hi = !s1_q.jog_rotation[15] && (|s1_q.jog_rotation[14:7]);

  always_comb begin
    priority if (rot_lo) begin
      jog_x = AXIS_MIN;
    end else if (rot_hi) begin
      jog_x = AXIS_MAX;
    end else begin
      jog_x = {~s1_q.jog_rotation[7], s1_q.jog_rotation[6:0]};
    end
  end

  // --------------------------------------------------------------------------
  // new raw axes and result
  // --------------------------------------------------------------------------
  always_comb begin
    raw_new  = raw_cur;
    prev_we  = 1'b0;
    res_d    = '0;
    res_d.pad_index = s1_q.pad_index;

    if (!s1_q.report_present) begin
      // no packet: the pad falls back to centre
      raw_new = AXES_CENTRE;
    end else if (s1_q.plugged_in) begin
      if (is_analog) begin
        raw_new = '{s1_q.left_x, ly_filt, s1_q.right_x, s1_q.right_y};
        prev_we = 1'b1;
      end else if (is_twist) begin
        raw_new = '{s1_q.twist, AXIS_CENTRE, AXIS_CENTRE, AXIS_CENTRE};
        res_d.wheel_attached = wheel_pad;
      end else if (is_jog) begin
        raw_new = '{jog_x, AXIS_CENTRE, AXIS_CENTRE, AXIS_CENTRE};
        res_d.wheel_attached  = wheel_pad;
        res_d.jog_force       = jog_force;
        res_d.jog_force_valid = 1'b1;
      end else begin
        raw_new = AXES_CENTRE;
      end
    end
    // an unplugged report keeps the stored axes but still resolves them

    res_d.raw = raw_new;
    if (s1_q.report_present) begin
      res_d.activity_seen = far_from_centre(raw_new.lx) || far_from_centre(raw_new.ly) ||
                            far_from_centre(raw_new.rx) || far_from_centre(raw_new.ry);
      res_d.resolved_x = resolve_axis(raw_new.lx, s1_q.buttons_held,
                                      left_mask_q, right_mask_q, follow);
      res_d.resolved_y = resolve_axis(raw_new.ly, s1_q.buttons_held,
                                      up_mask_q, down_mask_q, follow);
    end else begin
      res_d.resolved_x = AXIS_CENTRE;
      res_d.resolved_y = AXIS_CENTRE;
    end

    // a pad beyond the table leaves state alone and reports centre
    if (!pad_ok) begin
      res_d     = '0;
      res_d.pad_index  = s1_q.pad_index;
      res_d.raw        = AXES_CENTRE;
      res_d.resolved_x = AXIS_CENTRE;
      res_d.resolved_y = AXIS_CENTRE;
      prev_we   = 1'b0;
    end
  end

  assign raw_we = advance && pad_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PADS; i++) begin
        raw_axes_q[i] <= AXES_CENTRE;
        prev_ly_q[i]  <= 8'd0;
      end
    end else begin
      if (raw_we) begin
        raw_axes_q[pad_idx] <= raw_new;
      end
      // previous left-y tracks the unfiltered byte
      if (raw_we && prev_we) begin
        prev_ly_q[pad_idx] <= s1_q.left_y;
      end
    end
  end

  // --------------------------------------------------------------------------
  // outputs
  // --------------------------------------------------------------------------
  assign out_valid_o       = out_valid_q;
  assign out_pad_index_o   = out_q.pad_index;
  assign raw_left_x_o      = out_q.raw.lx;
  assign raw_left_y_o      = out_q.raw.ly;
  assign raw_right_x_o     = out_q.raw.rx;
  assign raw_right_y_o     = out_q.raw.ry;
  assign resolved_x_o      = out_q.resolved_x;
  assign resolved_y_o      = out_q.resolved_y;
  assign activity_seen_o   = out_q.activity_seen;
  assign jog_force_o       = out_q.jog_force;
  assign jog_force_valid_o = out_q.jog_force_valid;
  assign wheel_attached_o  = out_q.wheel_attached;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // the input side only backs up while a transaction sits in the input register
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  // jog force is zero unless a jog report produced it
  a_force_only_on_jog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !jog_force_valid_o) |-> (jog_force_o == 8'd0))
    else $error("jog force without a jog report");

  // a wheel is only flagged for the low pads
  a_wheel_pad_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && wheel_attached_o) |-> (5'(out_pad_index_o) < 5'(WHEEL_PADS)))
    else $error("wheel flagged on a high pad");

  // a report with no packet leaves its pad centred
  a_absent_centres: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !s1_q.report_present && pad_ok) |=>
      (raw_axes_q[$past(pad_idx)] == AXES_CENTRE))
    else $error("absent report did not centre the pad");

endmodule

`default_nettype wire
